### hw/rtl/imr_pkg.sv
// ----------------------------------------------------------------------------
// imr_pkg
// shared types and constants of the interval map with range assignment
// ----------------------------------------------------------------------------
`default_nettype none

package imr_pkg;

  localparam int unsigned CAPACITY_DEF    = 64;
  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam int unsigned KEY_W           = 64;
  localparam int unsigned IO_VALUE_W      = 32;

  localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
  localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

  typedef enum logic [1:0] {
    MODE_ASSIGN = 2'd0,
    MODE_QUERY  = 2'd1,
    MODE_TAIL   = 2'd2,
    MODE_RSVD   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_RANGE = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_PAST  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_SHL,
    CELL_SHR,
    CELL_WRITE,
    CELL_CLEAR
  } cell_op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_PLAN,
    S_SHIFT,
    S_WRITE
  } state_e;

  typedef struct packed {
    cell_op_e op;
    logic     w0_en;
    logic     w1_en;
  } cell_ctl_t;

endpackage

`default_nettype wire

### hw/rtl/imr_cell.sv
// ----------------------------------------------------------------------------
// imr_cell
// one breakpoint slot: holds key and value, compares against both bounds
// and takes a neighbor entry on shifts
// ----------------------------------------------------------------------------
`default_nettype none

module imr_cell #(
  parameter int unsigned IDX         = 0,
  parameter int unsigned CW          = 7,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  imr_pkg::cell_ctl_t              ctl_i,
  input  logic [CW-1:0]                   start_i,
  input  logic [CW-1:0]                   count_i,
  input  logic [CW-1:0]                   w0_idx_i,
  input  logic [CW-1:0]                   w1_idx_i,
  input  logic signed [imr_pkg::KEY_W-1:0] w0_key_i,
  input  logic [VALUE_WIDTH-1:0]          w0_val_i,
  input  logic signed [imr_pkg::KEY_W-1:0] w1_key_i,
  input  logic [VALUE_WIDTH-1:0]          w1_val_i,
  input  logic [VALUE_WIDTH-1:0]          clr_val_i,
  input  logic signed [imr_pkg::KEY_W-1:0] cmp_a_i,
  input  logic signed [imr_pkg::KEY_W-1:0] cmp_b_i,
  input  logic signed [imr_pkg::KEY_W-1:0] left_key_i,
  input  logic [VALUE_WIDTH-1:0]          left_val_i,
  input  logic signed [imr_pkg::KEY_W-1:0] right_key_i,
  input  logic [VALUE_WIDTH-1:0]          right_val_i,
  output logic signed [imr_pkg::KEY_W-1:0] key_o,
  output logic [VALUE_WIDTH-1:0]          val_o,
  output logic                            valid_o,
  output logic                            a_lt_o,
  output logic                            b_le_o
);
  import imr_pkg::*;

  localparam logic [CW-1:0] IDX_C = CW'(IDX);

  logic signed [KEY_W-1:0] key_q, key_d;
  logic [VALUE_WIDTH-1:0]  val_q, val_d;

  always_comb begin
    key_d = key_q;
    val_d = val_q;
    unique case (ctl_i.op)
      CELL_SHL: begin
        if (IDX_C >= start_i) begin
          key_d = right_key_i;
          val_d = right_val_i;
        end
      end
      CELL_SHR: begin
        if (IDX_C > start_i) begin
          key_d = left_key_i;
          val_d = left_val_i;
        end
      end
      CELL_WRITE: begin
        if (ctl_i.w0_en && IDX_C == w0_idx_i) begin
          key_d = w0_key_i;
          val_d = w0_val_i;
        end else if (ctl_i.w1_en && IDX_C == w1_idx_i) begin
          key_d = w1_key_i;
          val_d = w1_val_i;
        end
      end
      CELL_CLEAR: begin
        if (IDX == 0) begin
          key_d = KEY_MIN;
          val_d = clr_val_i;
        end
      end
      default: begin
        key_d = key_q;
        val_d = val_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= KEY_MIN;
      val_q <= '0;
    end else begin
      key_q <= key_d;
      val_q <= val_d;
    end
  end

  assign key_o   = key_q;
  assign val_o   = val_q;
  assign valid_o = IDX_C < count_i;
  assign a_lt_o  = valid_o && (key_q < cmp_a_i);
  assign b_le_o  = valid_o && !(cmp_b_i < key_q);

endmodule

`default_nettype wire

### hw/rtl/interval_map_range_assign.sv
// ----------------------------------------------------------------------------
// interval_map_range_assign
// piecewise-constant map over signed 64-bit keys kept as a row of breakpoint
// cells; range assign, point query and tail assign
// ----------------------------------------------------------------------------
// flow: an accepted transaction passes S_EVAL and S_PLAN, then S_SHIFT if needed,
//   moving the upper part of the table one position per step (at most CAPACITY)
//   by single-step shifts of the cell row, then S_WRITE, which waits while a
//   result waits at the output; no new item is taken until S_IDLE is reached again
// reset: table holds one entry (minimum key, value 0), count one, no result
`default_nettype none

module interval_map_range_assign #(
  parameter int unsigned CAPACITY    = imr_pkg::CAPACITY_DEF,
  parameter int unsigned VALUE_WIDTH = imr_pkg::VALUE_WIDTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [159:0] s_axis_tdata,  // lower_key, upper_key, new_value
  input  logic [1:0]   s_axis_tuser,  // mode
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [159:0] m_axis_tdata,  // value_out, interval_start, interval_end
  output logic [1:0]   m_axis_tuser,  // status
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [31:0]  cfg_data_i
);
  import imr_pkg::*;

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned WW = CW + 2;
  localparam logic [WW-1:0] CAP_W = WW'(CAPACITY);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [VALUE_WIDTH-1:0]  val_t;

  state_e state_q, state_d;

  mode_e     mode_q;
  key_t      lo_q, hi_q;
  val_t      val_q;
  logic [CW-1:0] count_q, count_d;

  logic [IW-1:0] pidx_q, qidx_q;
  val_t      vp_q, vq_q, vlast_q;
  key_t      kq_q, knext_q, klast_q;

  logic [CW-1:0] shift_cnt_q, start_q, n_q;
  logic          shift_left_q;
  logic          w0_en_q, w1_en_q;
  logic [CW-1:0] w0_idx_q, w1_idx_q;
  key_t          w0_key_q, w1_key_q;
  val_t          w0_val_q, w1_val_q;
  status_e       status_q;

  logic         out_valid_q;
  logic [159:0] out_data_q;
  status_e      out_status_q;

  logic [63:0] in_val64, cfg_val64, vq64;
  val_t        in_val, cfg_val;

  logic in_fire, cfg_fire, out_free;
  cell_ctl_t ctl;

  key_t key_w [CAPACITY];
  val_t val_w [CAPACITY];
  logic [CAPACITY-1:0] valid_w, a_lt_w, b_le_w;

  assign in_val64  = {32'b0, s_axis_tdata[159:128]};
  assign in_val    = in_val64[VALUE_WIDTH-1:0];
  assign cfg_val64 = {32'b0, cfg_data_i};
  assign cfg_val   = cfg_val64[VALUE_WIDTH-1:0];

  assign s_axis_tready = (state_q == S_IDLE) && !cfg_valid_i;
  assign cfg_ready_o   = (state_q == S_IDLE);
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign cfg_fire = cfg_valid_i && cfg_ready_o;
  assign out_free = !out_valid_q || m_axis_tready;

  // cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    key_t lk, rk;
    val_t lv, rv;
    if (i == 0) begin : g_first
      assign lk = key_w[0];
      assign lv = val_w[0];
    end else begin : g_mid
      assign lk = key_w[i-1];
      assign lv = val_w[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign rk = KEY_MIN;
      assign rv = '0;
    end else begin : g_inner
      assign rk = key_w[i+1];
      assign rv = val_w[i+1];
    end
    imr_cell #(
      .IDX        (i),
      .CW         (CW),
      .VALUE_WIDTH(VALUE_WIDTH)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .start_i    (start_q),
      .count_i    (count_q),
      .w0_idx_i   (w0_idx_q),
      .w1_idx_i   (w1_idx_q),
      .w0_key_i   (w0_key_q),
      .w0_val_i   (w0_val_q),
      .w1_key_i   (w1_key_q),
      .w1_val_i   (w1_val_q),
      .clr_val_i  (cfg_val),
      .cmp_a_i    (lo_q),
      .cmp_b_i    (hi_q),
      .left_key_i (lk),
      .left_val_i (lv),
      .right_key_i(rk),
      .right_val_i(rv),
      .key_o      (key_w[i]),
      .val_o      (val_w[i]),
      .valid_o    (valid_w[i]),
      .a_lt_o     (a_lt_w[i]),
      .b_le_o     (b_le_w[i])
    );
  end

  // boundary selection over the row
  logic [IW-1:0] pidx_s, qidx_s;
  val_t vp_s, vq_s, vlast_s;
  key_t kq_s, knext_s, klast_s;

  always_comb begin
    logic na, nb, nv;
    pidx_s  = '0;
    qidx_s  = '0;
    vp_s    = '0;
    vq_s    = '0;
    vlast_s = '0;
    kq_s    = '0;
    knext_s = '0;
    klast_s = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      na = (i == CAPACITY - 1) ? 1'b0 : a_lt_w[(i + 1) % CAPACITY];
      nb = (i == CAPACITY - 1) ? 1'b0 : b_le_w[(i + 1) % CAPACITY];
      nv = (i == CAPACITY - 1) ? 1'b0 : valid_w[(i + 1) % CAPACITY];
      if (a_lt_w[i] && !na) begin
        pidx_s = pidx_s | IW'(i);
        vp_s   = vp_s | val_w[i];
      end
      if (b_le_w[i] && !nb) begin
        qidx_s  = qidx_s | IW'(i);
        vq_s    = vq_s | val_w[i];
        kq_s    = kq_s | key_w[i];
        knext_s = knext_s | (nv ? key_w[(i + 1) % CAPACITY] : KEY_MAX);
      end
      if (valid_w[i] && !nv) begin
        vlast_s = vlast_s | val_w[i];
        klast_s = klast_s | key_w[i];
      end
    end
  end

  // plan of the table change
  logic [WW-1:0] p_w, q_w, m_w, ins_w, n_w, cnt_w;
  logic          ins_lo, ins_hi, bad_rng;

  always_comb begin
    p_w     = WW'(pidx_q) + WW'(1);
    q_w     = WW'(qidx_q) + WW'(1);
    cnt_w   = WW'(count_q);
    m_w     = q_w - p_w;
    ins_lo  = (vp_q != val_q);
    ins_hi  = (vq_q != val_q);
    ins_w   = WW'(ins_lo) + WW'(ins_hi);
    n_w     = cnt_w - m_w + ins_w;
    bad_rng = !(lo_q < hi_q) || (lo_q == KEY_MIN) || (hi_q == KEY_MAX);
  end

  logic          w0_en_s, w1_en_s;
  logic [CW-1:0] w0_idx_s, n_s;
  status_e       status_s;

  always_comb begin
    w0_en_s  = 1'b0;
    w1_en_s  = 1'b0;
    w0_idx_s = CW'(p_w);
    n_s      = count_q;
    status_s = ST_OK;
    unique case (mode_q)
      MODE_ASSIGN: begin
        if (bad_rng) begin
          status_s = ST_BAD_RANGE;
        end else if (n_w > CAP_W) begin
          status_s = ST_FULL;
        end else begin
          w0_en_s = ins_lo;
          w1_en_s = ins_hi;
          n_s     = CW'(n_w);
        end
      end
      MODE_TAIL: begin
        w0_idx_s = count_q;
        if (lo_q == KEY_MAX) begin
          status_s = ST_BAD_RANGE;
        end else if (!(klast_q < lo_q)) begin
          status_s = ST_NOT_PAST;
        end else if (vlast_q == val_q) begin
          status_s = ST_OK;
        end else if (count_q >= CAP_C) begin
          status_s = ST_FULL;
        end else begin
          w0_en_s = 1'b1;
          n_s     = count_q + CW'(1);
        end
      end
      MODE_QUERY: status_s = ST_OK;
      default:    status_s = ST_BAD_RANGE;
    endcase
  end

  always_comb begin
    state_d = state_q;
    ctl     = '{op: CELL_HOLD, w0_en: 1'b0, w1_en: 1'b0};
    count_d = count_q;
    unique case (state_q)
      S_IDLE: begin
        if (cfg_fire) begin
          ctl.op  = CELL_CLEAR;
          count_d = CW'(1);
        end else if (in_fire) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: state_d = S_PLAN;
      S_PLAN: begin
        if (mode_q == MODE_ASSIGN && !bad_rng && n_w <= CAP_W && m_w != ins_w) begin
          state_d = S_SHIFT;
        end else begin
          state_d = S_WRITE;
        end
      end
      S_SHIFT: begin
        ctl.op = shift_left_q ? CELL_SHL : CELL_SHR;
        if (shift_cnt_q == CW'(1)) begin
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        if (out_free) begin
          ctl     = '{op: CELL_WRITE, w0_en: w0_en_q, w1_en: w1_en_q};
          count_d = n_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= CW'(1);
      out_valid_q <= 1'b0;
      shift_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (state_q == S_WRITE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == S_PLAN) begin
        shift_cnt_q <= (m_w > ins_w) ? CW'(m_w - ins_w) : CW'(ins_w - m_w);
      end else if (state_q == S_SHIFT) begin
        shift_cnt_q <= shift_cnt_q - CW'(1);
      end
    end
  end

  assign vq64 = 64'(vq_q);

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q <= mode_e'(s_axis_tuser);
      lo_q   <= s_axis_tdata[63:0];
      hi_q   <= (mode_e'(s_axis_tuser) == MODE_QUERY) ? s_axis_tdata[63:0]
                                                        : s_axis_tdata[127:64];
      val_q  <= in_val;
    end
    if (state_q == S_EVAL) begin
      pidx_q  <= pidx_s;
      qidx_q  <= qidx_s;
      vp_q    <= vp_s;
      vq_q    <= vq_s;
      kq_q    <= kq_s;
      knext_q <= knext_s;
      vlast_q <= vlast_s;
      klast_q <= klast_s;
    end
    if (state_q == S_PLAN) begin
      w0_en_q      <= w0_en_s;
      w1_en_q      <= w1_en_s;
      w0_key_q     <= lo_q;
      w0_val_q     <= val_q;
      w1_key_q     <= hi_q;
      w1_val_q     <= vq_q;
      w0_idx_q     <= w0_idx_s;
      w1_idx_q     <= CW'(p_w + WW'(ins_lo));
      shift_left_q <= (m_w > ins_w);
      start_q      <= (m_w > ins_w) ? CW'(p_w + ins_w) : CW'(q_w);
      n_q          <= n_s;
      status_q     <= status_s;
    end
    if (state_q == S_WRITE && out_free) begin
      out_status_q <= status_q;
      if (mode_q == MODE_QUERY) begin
        out_data_q <= {knext_q, kq_q, vq64[IO_VALUE_W-1:0]};
      end else begin
        out_data_q <= '0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_status_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) && (count_q <= CAP_C))
    else $error("entry count out of range");

  a_first_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_w[0] == KEY_MIN)
    else $error("first breakpoint lost the minimum key");

  a_shift_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT) |-> (shift_cnt_q != '0))
    else $error("shift with zero count");

  a_out_after_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WRITE && out_free) |=> (m_axis_tvalid && state_q == S_IDLE))
    else $error("result not presented after table update");

endmodule

`default_nettype wire

### tb/sv/interval_map_range_assign_tb.sv
// ----------------------------------------------------------------------------
// interval_map_range_assign_tb
// Self-checking testbench of the interval map. A queue of stimulus feeds a
// stream driver. A local breakpoint table predicts the result of every
// accepted transaction, and the monitor checks each result field by field.
// The run covers several default values, a directed part, table-full
// sequences, random range work and long receiver hold-offs.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module interval_map_range_assign_tb;
  import imr_pkg::*;

  localparam int unsigned CAP = CAPACITY_DEF;
  localparam int unsigned CYCLE_LIMIT = 2000000;

  typedef logic signed [KEY_W-1:0] key_t;

  typedef struct {
    mode_e       mode;
    key_t        lo;
    key_t        hi;
    logic [31:0] val;
  } map_op_t;

  typedef struct {
    logic [31:0] value;
    key_t        span_lo;
    key_t        span_hi;
    status_e     st;
  } map_result_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [159:0] s_axis_tdata = '0;  // lower_key, upper_key, new_value
  logic [1:0]   s_axis_tuser = '0;  // mode
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [159:0] m_axis_tdata;       // value_out, interval_start, interval_end
  logic [1:0]   m_axis_tuser;       // status
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [31:0]  cfg_data_i = '0;

  interval_map_range_assign DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // predicted breakpoint table
  key_t        bp_key [CAP];
  logic [31:0] bp_val [CAP];
  int          bp_count;
  logic [31:0] base_value;

  map_op_t     pending_ops [$];
  map_result_t expected_results [$];
  int          errors = 0;
  bit          no_idle = 0;
  bit          hold_req = 0, hold_ack = 0;
  int          hold_cnt = 0;
  bit          in_took = 0;
  int          gap_left = 0;
  int          stall_left = 0;
  int          cycles = 0;

  function automatic void clear_table(logic [31:0] v);
    base_value = v;
    for (int i = 0; i < CAP; i++) begin
      bp_key[i] = '0;
      bp_val[i] = '0;
    end
    bp_key[0] = KEY_MIN;
    bp_val[0] = v;
    bp_count = 1;
  endfunction

  function automatic int find_interval(key_t x);
    int idx;
    idx = 0;
    for (int i = 1; i < bp_count; i++)
      if (bp_key[i] <= x) idx = i;
    return idx;
  endfunction

  function automatic status_e assign_range(key_t lo, key_t hi, logic [31:0] v);
    key_t        nk [CAP+2];
    logic [31:0] nv [CAP+2];
    logic [31:0] at_hi;
    int          n, i;
    n = 0;
    i = 0;
    if (lo >= hi || lo == KEY_MIN || hi == KEY_MAX) return ST_BAD_RANGE;
    at_hi = bp_val[find_interval(hi)];
    while (i < bp_count && bp_key[i] < lo) begin
      nk[n] = bp_key[i];
      nv[n] = bp_val[i];
      n++;
      i++;
    end
    if (nv[n-1] != v) begin
      nk[n] = lo;
      nv[n] = v;
      n++;
    end
    if (at_hi != v) begin
      nk[n] = hi;
      nv[n] = at_hi;
      n++;
    end
    for (i = 0; i < bp_count; i++)
      if (hi < bp_key[i]) begin
        if (n >= CAP + 2) return ST_FULL;
        nk[n] = bp_key[i];
        nv[n] = bp_val[i];
        n++;
      end
    if (n > CAP) return ST_FULL;
    for (i = 0; i < n; i++) begin
      bp_key[i] = nk[i];
      bp_val[i] = nv[i];
    end
    bp_count = n;
    return ST_OK;
  endfunction

  function automatic status_e assign_tail(key_t from, logic [31:0] v);
    if (from == KEY_MAX) return ST_BAD_RANGE;
    if (bp_key[bp_count-1] >= from) return ST_NOT_PAST;
    if (bp_val[bp_count-1] == v) return ST_OK;
    if (bp_count >= CAP) return ST_FULL;
    bp_key[bp_count] = from;
    bp_val[bp_count] = v;
    bp_count++;
    return ST_OK;
  endfunction

  function automatic map_result_t apply_op(map_op_t op);
    map_result_t r;
    int idx;
    r.value = '0;
    r.span_lo = '0;
    r.span_hi = '0;
    r.st = ST_OK;
    case (op.mode)
      MODE_ASSIGN: r.st = assign_range(op.lo, op.hi, op.val);
      MODE_QUERY: begin
        idx = find_interval(op.lo);
        r.value = bp_val[idx];
        r.span_lo = bp_key[idx];
        r.span_hi = (idx + 1 < bp_count) ? bp_key[idx+1] : KEY_MAX;
      end
      MODE_TAIL: r.st = assign_tail(op.lo, op.val);
      default: r.st = ST_BAD_RANGE;
    endcase
    return r;
  endfunction

  function automatic key_t pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return key_t'($signed($urandom_range(0, 400)) - 200);
    if (r < 75) begin
      case ($urandom_range(0, 3))
        0: return KEY_MIN;
        1: return KEY_MAX;
        2: return KEY_MIN + 1;
        default: return KEY_MAX - 1;
      endcase
    end
    return {$urandom, $urandom};
  endfunction

  function automatic logic [31:0] pick_value();
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 5);
    return $urandom;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void push_op(mode_e m, key_t lo, key_t hi, logic [31:0] v);
    map_op_t op;
    op.mode = m;
    op.lo = lo;
    op.hi = hi;
    op.val = v;
    pending_ops.push_back(op);
  endfunction

  function automatic void push_random_ops(int count);
    key_t lo;
    int   r;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      lo = pick_key();
      if (r < 50) begin
        // mostly well-formed ranges that overlap existing breakpoints
        if ($urandom_range(0, 9) < 8)
          push_op(MODE_ASSIGN, lo, lo + $urandom_range(1, 40), pick_value());
        else
          push_op(MODE_ASSIGN, lo, pick_key(), pick_value());
      end else if (r < 82) begin
        push_op(MODE_QUERY, lo, pick_key(), $urandom);
      end else if (r < 96) begin
        push_op(MODE_TAIL, lo, pick_key(), pick_value());
      end else begin
        push_op(MODE_RSVD, lo, pick_key(), $urandom);
      end
    end
  endfunction

  // driver
  always @(negedge clk_i) begin
    map_op_t op;
    if (rst_ni && (in_took || !s_axis_tvalid)) begin
      if (gap_left != 0) begin
        s_axis_tvalid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_ops.size() != 0) begin
        op = pending_ops.pop_front();
        s_axis_tdata <= {op.val, op.hi, op.lo};
        s_axis_tuser <= op.mode;
        s_axis_tvalid <= 1'b1;
        gap_left <= pick_gap();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // long receiver hold-off
  always @(negedge clk_i) begin
    if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (hold_req != hold_ack) begin
      hold_cnt <= 300;
      hold_ack <= hold_req;
    end
  end

  // receiver
  always @(negedge clk_i) begin
    if (hold_cnt != 0 || stall_left != 0) begin
      m_axis_tready <= 1'b0;
      if (stall_left != 0) stall_left <= stall_left - 1;
    end else if (no_idle) begin
      m_axis_tready <= 1'b1;
    end else if ($urandom_range(0, 99) < 3) begin
      m_axis_tready <= 1'b0;
      stall_left <= $urandom_range(10, 40);
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) < 70);
    end
  end

  // input acceptance and result check
  always @(posedge clk_i) begin
    map_op_t     op;
    map_result_t ex;
    in_took <= s_axis_tvalid && s_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      op.lo = s_axis_tdata[63:0];
      op.hi = s_axis_tdata[127:64];
      op.val = s_axis_tdata[159:128];
      op.mode = mode_e'(s_axis_tuser);
      expected_results.push_back(apply_op(op));
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result transaction %h/%h", $time, m_axis_tdata,
                 m_axis_tuser);
        errors++;
      end else begin
        ex = expected_results.pop_front();
        if (m_axis_tdata[31:0] !== ex.value) begin
          $display("%0t: value_out exp %h got %h", $time, ex.value, m_axis_tdata[31:0]);
          errors++;
        end
        if (m_axis_tdata[95:32] !== ex.span_lo) begin
          $display("%0t: interval_start exp %h got %h", $time, ex.span_lo,
                   m_axis_tdata[95:32]);
          errors++;
        end
        if (m_axis_tdata[159:96] !== ex.span_hi) begin
          $display("%0t: interval_end exp %h got %h", $time, ex.span_hi,
                   m_axis_tdata[159:96]);
          errors++;
        end
        if (m_axis_tuser !== ex.st) begin
          $display("%0t: status exp %0d got %0d", $time, ex.st, m_axis_tuser);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("interval_map_range_assign_tb NOT OK");
      $finish;
    end
  end

  // ready depends on registered state only, so it is stable at the falling edge
  task automatic write_default(logic [31:0] v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    while (!cfg_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    clear_table(v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    while (pending_ops.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  initial begin
    clear_table('0);
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part on the reset table, then with default 0 written
    push_op(MODE_QUERY, KEY_MIN, '0, '0);
    push_op(MODE_QUERY, KEY_MAX, '0, '0);
    drain();
    write_default('0);
    push_op(MODE_ASSIGN, 10, 10, 7);
    push_op(MODE_ASSIGN, 20, 10, 7);
    push_op(MODE_ASSIGN, KEY_MIN, 10, 7);
    push_op(MODE_ASSIGN, 10, KEY_MAX, 7);
    push_op(MODE_ASSIGN, 10, 20, 7);
    push_op(MODE_QUERY, 15, '0, '0);
    push_op(MODE_QUERY, 20, '0, '0);
    push_op(MODE_ASSIGN, 20, 30, 7);
    push_op(MODE_ASSIGN, KEY_MIN + 1, KEY_MAX - 1, 32'hFFFF_FFFF);
    push_op(MODE_QUERY, KEY_MIN, '0, '0);
    push_op(MODE_QUERY, KEY_MAX, '0, '0);
    push_op(MODE_ASSIGN, -5, 5, 0);
    push_op(MODE_TAIL, KEY_MAX, '0, 3);
    push_op(MODE_TAIL, -100, '0, 3);
    push_op(MODE_TAIL, 1000, '0, 32'hFFFF_FFFF);
    push_op(MODE_TAIL, 1000, '0, 4);
    push_op(MODE_TAIL, 2000, '0, 4);
    push_op(MODE_RSVD, KEY_MAX, KEY_MIN, 32'hFFFF_FFFF);
    push_op(MODE_QUERY, 1000, '0, '0);
    push_op(MODE_QUERY, -1, '0, '0);
    drain();

    // all-ones default, random work with a long hold-off
    write_default(32'hFFFF_FFFF);
    push_random_ops(500);
    repeat (50) @(posedge clk_i);
    hold_req = ~hold_req;
    drain();

    // fill the table by appends, then overflow it
    write_default($urandom);
    for (int k = 0; k < 70; k++) push_op(MODE_TAIL, key_t'(k * 10), '0, k + 1);
    push_op(MODE_ASSIGN, 3, 4, 99);
    push_op(MODE_ASSIGN, 5, 25, 99);
    no_idle = 1;
    push_random_ops(100);
    drain();
    no_idle = 0;

    write_default($urandom_range(0, 5));
    push_random_ops(600);
    drain();

    write_default('0);
    push_random_ops(300);
    repeat (30) @(posedge clk_i);
    hold_req = ~hold_req;
    drain();

    if (errors == 0)
      $display("interval_map_range_assign_tb OK");
    else
      $display("interval_map_range_assign_tb NOT OK");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/imr_pkg.sv
hw/rtl/imr_cell.sv
hw/rtl/interval_map_range_assign.sv
tb/sv/interval_map_range_assign_tb.sv
